[design/mpp_pkg.sv]
// Shared types and codes for the MMS PDU header parser.
// No dependencies; used by every module of the block.
package mpp_pkg;

   localparam int QDEPTH = 4;

   localparam logic [3:0] TK_SHORT  = 4'd0;
   localparam logic [3:0] TK_INT    = 4'd1;
   localparam logic [3:0] TK_TBEGIN = 4'd2;
   localparam logic [3:0] TK_TBYTE  = 4'd3;
   localparam logic [3:0] TK_TEND   = 4'd4;
   localparam logic [3:0] TK_CTYPE  = 4'd5;
   localparam logic [3:0] TK_PARAM  = 4'd6;
   localparam logic [3:0] TK_PCOUNT = 4'd7;
   localparam logic [3:0] TK_HLEN   = 4'd8;
   localparam logic [3:0] TK_DLEN   = 4'd9;
   localparam logic [3:0] TK_PTYPE  = 4'd10;
   localparam logic [3:0] TK_BODY   = 4'd11;
   localparam logic [3:0] TK_PEND   = 4'd12;
   localparam logic [3:0] TK_ERR    = 4'd13;
   localparam logic [3:0] TK_DONE   = 4'd14;

   localparam logic [2:0] E_UNKNOWN  = 3'd0;
   localparam logic [2:0] E_YESNO    = 3'd1;
   localparam logic [2:0] E_OCTETS   = 3'd2;
   localparam logic [2:0] E_OVERFLOW = 3'd4;
   localparam logic [2:0] E_OVERRUN  = 3'd5;
   localparam logic [2:0] E_TRUNC    = 3'd6;

   localparam logic [7:0] F_MSGTYPE = 8'h8C;
   localparam logic [7:0] F_VERSION = 8'h8D;
   localparam logic [7:0] F_CTYPE   = 8'h84;
   localparam logic [7:0] B_SENT    = 8'h80;

   typedef enum logic [28:0] {
      S_FIELD     = 29'b1 << 0,
      S_SHORT     = 29'b1 << 1,
      S_YESNO     = 29'b1 << 2,
      S_LCNT      = 29'b1 << 3,
      S_LDAT      = 29'b1 << 4,
      S_TXT_HDR   = 29'b1 << 5,
      S_ENC0      = 29'b1 << 6,
      S_ENCSKIP   = 29'b1 << 7,
      S_ENCCS     = 29'b1 << 8,
      S_ENCRAW    = 29'b1 << 9,
      S_CLASS     = 29'b1 << 10,
      S_XTEST     = 29'b1 << 11,
      S_CT0       = 29'b1 << 12,
      S_CT_UV     = 29'b1 << 13,
      S_CT1       = 29'b1 << 14,
      S_TXT_CT    = 29'b1 << 15,
      S_PARAM     = 29'b1 << 16,
      S_PARAMV    = 29'b1 << 17,
      S_PCOUNT    = 29'b1 << 18,
      S_HLEN      = 29'b1 << 19,
      S_DLEN      = 29'b1 << 20,
      S_PT0       = 29'b1 << 21,
      S_PT_UV     = 29'b1 << 22,
      S_PT1       = 29'b1 << 23,
      S_TXT_PTYPE = 29'b1 << 24,
      S_TXT_NAME  = 29'b1 << 25,
      S_HSKIP     = 29'b1 << 26,
      S_DATA      = 29'b1 << 27,
      S_IDLE      = 29'b1 << 28
   } pstate_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  field;
      logic [63:0] value;
      logic [7:0]  data;
      logic [2:0]  err;
   } tok_type;

   typedef struct packed {
      tok_type [2:0] tok;
      logic [1:0]    cnt;
   } grp_type;

   typedef struct packed {
      pstate_type  st;
      logic [7:0]  fld;
      logic [63:0] acc;
      logic [4:0]  oct;
      logic        ts;
      logic        sent;
      logic        mp;
      logic [63:0] parts;
      logic [63:0] hb;
      logic [63:0] db;
      logic        nw;
   } pst_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[design/mpp_front.sv]
// Front end: byte parser that turns each accepted byte into a group of up to three tokens.
// Depends on mpp_pkg.
module mpp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_first,
   input  logic             in_end,
   output logic             push,
   output mpp_pkg::grp_type grp
);

   typedef struct packed {
      mpp_pkg::pst_type s;
      mpp_pkg::grp_type g;
   } ps_type;

   mpp_pkg::pst_type pst_ff, pst_in;

   function automatic mpp_pkg::pst_type clr();
      mpp_pkg::pst_type s;
      s = '0;
      s.st = mpp_pkg::S_FIELD;
      return s;
   endfunction

   function automatic ps_type emit(ps_type p, logic [3:0] k, logic [7:0] f,
                                   logic [63:0] v, logic [7:0] d, logic [2:0] e);
      mpp_pkg::tok_type t;
      t.kind = k; t.field = f; t.value = v; t.data = d; t.err = e;
      if (p.g.cnt != 2'd3) begin
         p.g.tok[p.g.cnt] = t;
         p.g.cnt = p.g.cnt + 2'd1;
      end
      return p;
   endfunction

   function automatic ps_type text_begin(ps_type p, logic [63:0] cs);
      p.s.ts = 1'b0;
      return emit(p, mpp_pkg::TK_TBEGIN, p.s.fld, cs, 8'd0, 3'd0);
   endfunction

   function automatic ps_type text_char(ps_type p, logic [7:0] b);
      if (b == 8'd0) begin
         p = emit(p, mpp_pkg::TK_TEND, p.s.fld, 64'd0, 8'd0, 3'd0);
      end else if (!((b == 8'h7F && !p.s.ts) || b[7] || b == 8'h22)) begin
         p.s.ts = 1'b1;
         p = emit(p, mpp_pkg::TK_TBYTE, p.s.fld, 64'd0, b, 3'd0);
      end
      return p;
   endfunction

   function automatic ps_type uv_byte(ps_type p, logic [7:0] b);
      if (p.s.acc[63:57] != 7'd0) begin
         p = emit(p, mpp_pkg::TK_ERR, p.s.fld, 64'd0, 8'd0, mpp_pkg::E_OVERFLOW);
         p.s.st = mpp_pkg::S_IDLE;
      end else begin
         p.s.acc = {p.s.acc[56:0], b[6:0]};
      end
      return p;
   endfunction

   function automatic ps_type part_end(ps_type p);
      p.s.parts = p.s.parts - 64'd1;
      p = emit(p, mpp_pkg::TK_PEND, 8'd0, p.s.parts, 8'd0, 3'd0);
      p.s.acc = 64'd0;
      p.s.st = (p.s.parts == 64'd0) ? mpp_pkg::S_IDLE : mpp_pkg::S_HLEN;
      return p;
   endfunction

   function automatic ps_type enter_data(ps_type p);
      if (p.s.db == 64'd0) p = part_end(p);
      else p.s.st = mpp_pkg::S_DATA;
      return p;
   endfunction

   function automatic ps_type header_done(ps_type p);
      if (p.s.hb == 64'd0) p = enter_data(p);
      else p.s.st = mpp_pkg::S_HSKIP;
      return p;
   endfunction

   function automatic ps_type ptype_done(ps_type p);
      if (p.s.nw) begin
         p = text_begin(p, 64'd0);
         p.s.st = mpp_pkg::S_TXT_NAME;
      end else begin
         p = header_done(p);
      end
      return p;
   endfunction

   function automatic ps_type ct_byte(ps_type p, logic [7:0] b, logic allow);
      if (allow && b <= 8'd31) begin
         p.s.acc = 64'd0;
         p.s.st = (b == 8'd31) ? mpp_pkg::S_CT_UV : mpp_pkg::S_CT1;
      end else if (b > 8'd31 && !b[7]) begin
         p = text_begin(p, 64'd0);
         p.s.st = mpp_pkg::S_TXT_CT;
         p = text_char(p, b);
      end else begin
         p = emit(p, mpp_pkg::TK_CTYPE, mpp_pkg::F_CTYPE, {57'd0, b[6:0]}, 8'd0, 3'd0);
         if (b[6:0] == 7'h23 || b[6:0] == 7'h33) p.s.mp = 1'b1;
         p.s.st = mpp_pkg::S_PARAM;
      end
      return p;
   endfunction

   function automatic ps_type pt_byte(ps_type p, logic [7:0] b, logic allow);
      if (allow && b <= 8'd31) begin
         p.s.acc = 64'd0;
         p.s.st = (b == 8'd31) ? mpp_pkg::S_PT_UV : mpp_pkg::S_PT1;
      end else if (b > 8'd31 && !b[7]) begin
         p = text_begin(p, 64'd0);
         p.s.st = mpp_pkg::S_TXT_PTYPE;
         p = text_char(p, b);
      end else begin
         p = emit(p, mpp_pkg::TK_PTYPE, 8'd0, {56'd0, b}, 8'd0, 3'd0);
         p = ptype_done(p);
      end
      return p;
   endfunction

   function automatic ps_type body_count(ps_type p, logic [7:0] b);
      logic fin;
      fin = (p.s.acc[63:57] == 7'd0) && !b[7];
      p = uv_byte(p, b);
      if (fin) begin
         p.s.parts = p.s.acc;
         p = emit(p, mpp_pkg::TK_PCOUNT, 8'd0, p.s.parts, 8'd0, 3'd0);
         p.s.acc = 64'd0;
         p.s.st = (p.s.parts == 64'd0) ? mpp_pkg::S_IDLE : mpp_pkg::S_HLEN;
      end
      return p;
   endfunction

   function automatic ps_type field_byte(ps_type p, logic [7:0] b);
      p.s.fld = b;
      case (b)
         8'h8C, 8'h8F, 8'h8D: p.s.st = mpp_pkg::S_SHORT;
         8'h98, 8'h8B: begin
            p = text_begin(p, 64'd0);
            p.s.st = mpp_pkg::S_TXT_HDR;
         end
         8'h89, 8'h97, 8'h96: p.s.st = mpp_pkg::S_ENC0;
         8'h86, 8'h90, 8'h91, 8'h94: p.s.st = mpp_pkg::S_YESNO;
         8'h88, 8'h85: p.s.st = mpp_pkg::S_LCNT;
         8'h8A: p.s.st = mpp_pkg::S_CLASS;
         8'h84: p.s.st = mpp_pkg::S_CT0;
         8'h99, 8'h9A: p.s.st = mpp_pkg::S_XTEST;
         default: p = emit(p, mpp_pkg::TK_ERR, b, 64'd0, 8'd0, mpp_pkg::E_UNKNOWN);
      endcase
      return p;
   endfunction

   ps_type p;
   logic   uvdone;
   logic   in_hdr;
   logic   skip;
   logic   complete;

   always_comb begin
      p.s = in_first ? clr() : pst_ff;
      p.g = '0;
      b_dummy: begin end
      uvdone = (p.s.acc[63:57] == 7'd0) && !in_byte[7];
      in_hdr = p.s.st == mpp_pkg::S_PT0 || p.s.st == mpp_pkg::S_PT_UV ||
               p.s.st == mpp_pkg::S_PT1 || p.s.st == mpp_pkg::S_TXT_PTYPE ||
               p.s.st == mpp_pkg::S_TXT_NAME || p.s.st == mpp_pkg::S_HSKIP;
      skip = 1'b0;
      if (in_hdr) begin
         if (p.s.hb == 64'd0) begin
            p = emit(p, mpp_pkg::TK_ERR, 8'd0, 64'd0, 8'd0, mpp_pkg::E_OVERRUN);
            p = enter_data(p);
            skip = 1'b1;
         end else begin
            p.s.hb = p.s.hb - 64'd1;
         end
      end
      if (!skip) begin
         case (p.s.st)
            mpp_pkg::S_FIELD: p = field_byte(p, in_byte);
            mpp_pkg::S_SHORT: begin
               if (p.s.fld == mpp_pkg::F_MSGTYPE && in_byte == mpp_pkg::B_SENT)
                  p.s.sent = 1'b1;
               p = emit(p, mpp_pkg::TK_SHORT, p.s.fld,
                        (p.s.fld == mpp_pkg::F_VERSION) ? {57'd0, in_byte[6:0]}
                                                        : {56'd0, in_byte},
                        8'd0, 3'd0);
               p.s.st = mpp_pkg::S_FIELD;
            end
            mpp_pkg::S_YESNO: begin
               if (in_byte == 8'h80 || in_byte == 8'h81)
                  p = emit(p, mpp_pkg::TK_SHORT, p.s.fld, {56'd0, in_byte}, 8'd0, 3'd0);
               else
                  p = emit(p, mpp_pkg::TK_ERR, p.s.fld, 64'd0, 8'd0, mpp_pkg::E_YESNO);
               p.s.st = mpp_pkg::S_FIELD;
            end
            mpp_pkg::S_LCNT: begin
               if (in_byte > 8'd30) begin
                  p = emit(p, mpp_pkg::TK_ERR, p.s.fld, 64'd0, 8'd0, mpp_pkg::E_OCTETS);
                  p.s.st = mpp_pkg::S_FIELD;
               end else if (in_byte == 8'd0) begin
                  p = emit(p, mpp_pkg::TK_INT, p.s.fld, 64'd0, 8'd0, 3'd0);
                  p.s.st = mpp_pkg::S_FIELD;
               end else begin
                  p.s.oct = in_byte[4:0];
                  p.s.acc = 64'd0;
                  p.s.st = mpp_pkg::S_LDAT;
               end
            end
            mpp_pkg::S_LDAT: begin
               p.s.acc = {p.s.acc[55:0], in_byte};
               p.s.oct = p.s.oct - 5'd1;
               if (p.s.oct == 5'd0) begin
                  p = emit(p, mpp_pkg::TK_INT, p.s.fld, p.s.acc, 8'd0, 3'd0);
                  p.s.st = mpp_pkg::S_FIELD;
               end
            end
            mpp_pkg::S_TXT_HDR: begin
               p = text_char(p, in_byte);
               if (in_byte == 8'd0) p.s.st = mpp_pkg::S_FIELD;
            end
            mpp_pkg::S_ENC0: begin
               if (in_byte == 8'd1) begin
                  p.s.st = mpp_pkg::S_ENCSKIP;
               end else if (in_byte <= 8'd31) begin
                  p.s.st = mpp_pkg::S_ENCCS;
               end else begin
                  p = text_begin(p, 64'd0);
                  p.s.st = mpp_pkg::S_TXT_HDR;
                  p = text_char(p, in_byte);
               end
            end
            mpp_pkg::S_ENCSKIP: begin
               p = text_begin(p, {56'd0, in_byte});
               p = emit(p, mpp_pkg::TK_TEND, p.s.fld, 64'd0, 8'd0, 3'd0);
               p.s.st = mpp_pkg::S_FIELD;
            end
            mpp_pkg::S_ENCCS: begin
               p = text_begin(p, {56'd0, in_byte});
               p.s.st = mpp_pkg::S_ENCRAW;
            end
            mpp_pkg::S_ENCRAW: begin
               if (in_byte == 8'd0) begin
                  p = emit(p, mpp_pkg::TK_TEND, p.s.fld, 64'd0, 8'd0, 3'd0);
                  p.s.st = mpp_pkg::S_FIELD;
               end else begin
                  p = emit(p, mpp_pkg::TK_TBYTE, p.s.fld, 64'd0, in_byte, 3'd0);
               end
            end
            mpp_pkg::S_CLASS, mpp_pkg::S_XTEST: begin
               if ((p.s.st == mpp_pkg::S_CLASS && in_byte[7:2] == 6'b100000) ||
                   (p.s.st == mpp_pkg::S_XTEST && in_byte[7])) begin
                  p = emit(p, mpp_pkg::TK_SHORT, p.s.fld, {56'd0, in_byte}, 8'd0, 3'd0);
                  p.s.st = mpp_pkg::S_FIELD;
               end else begin
                  p = text_begin(p, 64'd0);
                  p.s.st = mpp_pkg::S_TXT_HDR;
                  p = text_char(p, in_byte);
                  if (in_byte == 8'd0) p.s.st = mpp_pkg::S_FIELD;
               end
            end
            mpp_pkg::S_CT0: p = ct_byte(p, in_byte, 1'b1);
            mpp_pkg::S_CT_UV: begin
               p = uv_byte(p, in_byte);
               if (uvdone) p.s.st = mpp_pkg::S_CT1;
            end
            mpp_pkg::S_CT1: p = ct_byte(p, in_byte, 1'b0);
            mpp_pkg::S_TXT_CT: begin
               p = text_char(p, in_byte);
               if (in_byte == 8'd0) p.s.st = mpp_pkg::S_PARAM;
            end
            mpp_pkg::S_PARAM: begin
               if (in_byte == 8'h89 || in_byte == 8'h8A) begin
                  p.s.fld = in_byte;
                  p.s.st = mpp_pkg::S_PARAMV;
               end else if (p.s.mp) begin
                  p.s.fld = 8'd0;
                  p.s.acc = 64'd0;
                  p.s.st = mpp_pkg::S_PCOUNT;
                  p = body_count(p, in_byte);
               end else begin
                  p.s.st = mpp_pkg::S_IDLE;
               end
            end
            mpp_pkg::S_PARAMV: begin
               if (!in_byte[7]) begin
                  p = text_begin(p, 64'd0);
                  p.s.st = mpp_pkg::S_TXT_CT;
                  p = text_char(p, in_byte);
               end else begin
                  p = emit(p, mpp_pkg::TK_PARAM, p.s.fld, {57'd0, in_byte[6:0]}, 8'd0, 3'd0);
                  p.s.st = mpp_pkg::S_PARAM;
               end
            end
            mpp_pkg::S_PCOUNT: p = body_count(p, in_byte);
            mpp_pkg::S_HLEN: begin
               p = uv_byte(p, in_byte);
               if (uvdone) begin
                  p.s.hb = p.s.acc;
                  p.s.nw = p.s.acc > 64'd4;
                  p = emit(p, mpp_pkg::TK_HLEN, 8'd0, p.s.hb, 8'd0, 3'd0);
                  p.s.acc = 64'd0;
                  p.s.st = mpp_pkg::S_DLEN;
               end
            end
            mpp_pkg::S_DLEN: begin
               p = uv_byte(p, in_byte);
               if (uvdone) begin
                  p.s.db = p.s.acc;
                  p = emit(p, mpp_pkg::TK_DLEN, 8'd0, p.s.db, 8'd0, 3'd0);
                  if (p.s.hb == 64'd0) p = enter_data(p);
                  else p.s.st = mpp_pkg::S_PT0;
               end
            end
            mpp_pkg::S_PT0: p = pt_byte(p, in_byte, 1'b1);
            mpp_pkg::S_PT_UV: begin
               p = uv_byte(p, in_byte);
               if (uvdone) p.s.st = mpp_pkg::S_PT1;
            end
            mpp_pkg::S_PT1: p = pt_byte(p, in_byte, 1'b0);
            mpp_pkg::S_TXT_PTYPE: begin
               p = text_char(p, in_byte);
               if (in_byte == 8'd0) p = ptype_done(p);
            end
            mpp_pkg::S_TXT_NAME: begin
               p = text_char(p, in_byte);
               if (in_byte == 8'd0) p = header_done(p);
            end
            mpp_pkg::S_HSKIP: begin
               if (p.s.hb == 64'd0) p = enter_data(p);
            end
            mpp_pkg::S_DATA: begin
               p = emit(p, mpp_pkg::TK_BODY, 8'd0, 64'd0, in_byte, 3'd0);
               p.s.db = p.s.db - 64'd1;
               if (p.s.db == 64'd0) p = part_end(p);
            end
            default: begin
            end
         endcase
      end
      complete = p.s.st == mpp_pkg::S_FIELD || p.s.st == mpp_pkg::S_IDLE ||
                 (p.s.st == mpp_pkg::S_PARAM && !p.s.mp);
      if (in_end) begin
         if (complete)
            p = emit(p, mpp_pkg::TK_DONE, 8'd0, {63'd0, p.s.sent}, 8'd0, 3'd0);
         else
            p = emit(p, mpp_pkg::TK_ERR, p.s.fld, 64'd0, 8'd0, mpp_pkg::E_TRUNC);
         p.s = clr();
      end
      pst_in = p.s;
   end

   assign grp  = p.g;
   assign push = in_valid && in_ready && (p.g.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pst_ff <= clr();
      end else if (in_valid && in_ready) begin
         pst_ff <= pst_in;
      end
   end

endmodule

[design/mpp_queue.sv]
// Short queue of token groups between the parser and the token serialiser.
// Depends on mpp_pkg.
module mpp_queue #(
   parameter int DEPTH = mpp_pkg::QDEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mpp_pkg::grp_type   wdata,
   input  logic               pop,
   output mpp_pkg::grp_type   rdata,
   output mpp_pkg::qstat_type stat
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mpp_pkg::grp_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_push, do_pop;

   assign stat.full  = cnt_ff == CW'(DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign rdata      = mem_ff[rp_ff];

   always_comb begin
      wp_in  = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
      rp_in  = (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
      cnt_in = cnt_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wp_ff <= wp_in;
         if (do_pop) rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[design/mpp_back.sv]
// Back end: walks each token group and drives one token a cycle into the output register unless stalled.
// Depends on mpp_pkg.
module mpp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  mpp_pkg::grp_type grp,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output mpp_pkg::tok_type out_tok,
   output logic             out_last
);

   logic [1:0]       idx_ff, idx_in;
   logic             vld_ff;
   mpp_pkg::tok_type tok_ff;
   logic             last_ff;
   logic             load;
   logic             fin;

   assign load = q_valid && (!vld_ff || out_ready);
   assign fin  = idx_ff == (grp.cnt - 2'd1);
   assign pop  = load && fin;

   always_comb begin
      idx_in = idx_ff;
      if (load) idx_in = fin ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) vld_ff <= 1'b1;
         else if (out_ready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= (idx_ff == 2'd3) ? grp.tok[0] : grp.tok[idx_ff];
         last_ff <= fin;
      end
   end

   assign out_valid = vld_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

endmodule

[design/mms_pdu_header_parser_unit.sv]
// MMS PDU header parser: one byte in per cycle, tokens out one per cycle, when not stalled.
// Path: a byte's tokens pass through the group queue, then the output register.
// Throughput: one byte per cycle while the group queue has room; a byte that
// yields n tokens (n up to 3) sends them out one token at a time.
// Reset: synchronous, clears parser state, queue pointers and the output valid flag.
// Depends on mpp_pkg, mpp_front, mpp_queue, mpp_back.
module mms_pdu_header_parser_unit #(
   parameter int QDEPTH = mpp_pkg::QDEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [7:0] field_code, [71:8] token_value,
                                    // [79:72] data_byte, [82:80] error_code
   output logic [3:0]  rsp_tuser,   // [3:0] token_kind
   output logic        rsp_tlast    // last_of_run
);

   mpp_pkg::grp_type   f_grp, q_grp;
   mpp_pkg::qstat_type q_stat;
   mpp_pkg::tok_type   tok;
   logic               push, pop;

   assign req_tready = !q_stat.full;

   mpp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_first (req_tuser),
      .in_end   (req_tlast),
      .push     (push),
      .grp      (f_grp)
   );

   mpp_queue #(.DEPTH(QDEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (f_grp),
      .pop   (pop),
      .rdata (q_grp),
      .stat  (q_stat)
   );

   mpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_stat.empty),
      .grp       (q_grp),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (tok),
      .out_last  (rsp_tlast)
   );

   assign rsp_tuser = tok.kind;
   assign rsp_tdata = {5'd0, tok.err, tok.data, tok.value, tok.field};

   a_qstat : assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty together");

   a_done_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == mpp_pkg::TK_DONE) |-> rsp_tlast)
      else $error("done token not last of run");

   a_rst_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("push into full queue");

endmodule
